[rtl/aio_pkg.sv]
`default_nettype none
package aio_pkg;

    localparam logic [9:0] LINE_PIXELS   = 10'd384;
    localparam logic [9:0] FRAME_LINES   = 10'd262;
    localparam logic [8:0] VISIBLE_LINES = 9'd224;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic CFG_DIP_SWITCHES = 1'b0;
    localparam logic CFG_GAME_SELECT  = 1'b1;

    localparam logic [7:0] DIP_RESET = 8'd136;

    localparam logic [13:0] PAGE_MASK     = 14'h3fc0;
    localparam logic [13:0] PAGE_SWITCH   = 14'h0800;
    localparam logic [13:0] PAGE_COIN     = 14'h0840;
    localparam logic [13:0] PAGE_START    = 14'h0880;
    localparam logic [13:0] PAGE_SERVICE  = 14'h08c0;
    localparam logic [13:0] BLOCK_MASK    = 14'h3c00;
    localparam logic [13:0] BLOCK_LINE    = 14'h0c00;
    localparam logic [13:0] BLOCK_SYNC    = 14'h1000;
    localparam logic [13:0] WBLOCK_MASK   = 14'h3f80;
    localparam logic [13:0] WBLOCK_LATCH  = 14'h0c00;
    localparam logic [13:0] WBLOCK_WDOG   = 14'h0c80;
    localparam logic [13:0] WBLOCK_IRQACK = 14'h0e00;
    localparam logic [13:0] TONE_ADDR     = 14'h0791;
    localparam logic [13:0] TONE_MIR_MASK = 14'h3c7f;
    localparam logic [13:0] TONE_MIR_ADDR = 14'h0011;

    localparam logic [5:0] SW_DIP_MASK = 6'h0b;
    localparam logic [5:0] SW_BIT_MASK = 6'h17;
    localparam logic [5:0] SW_DIP0     = 6'h00;
    localparam logic [5:0] SW_DIP1     = 6'h01;
    localparam logic [5:0] SW_DIP2     = 6'h02;
    localparam logic [5:0] SW_DIP3     = 6'h03;
    localparam logic [5:0] SW_GSEL_LO  = 6'h00;
    localparam logic [5:0] SW_TRIG0    = 6'h04;
    localparam logic [5:0] SW_TRIG1    = 6'h05;
    localparam logic [5:0] SW_SERVE    = 6'h06;
    localparam logic [5:0] SW_GSEL_HI  = 6'h07;

    localparam logic [2:0] WSEL_SERVE_LAMP  = 3'd1;
    localparam logic [2:0] WSEL_START1_LAMP = 3'd3;
    localparam logic [2:0] WSEL_START2_LAMP = 3'd4;
    localparam logic [2:0] WSEL_MASK0       = 3'd5;
    localparam logic [2:0] WSEL_MASK1       = 3'd6;
    localparam logic [2:0] WSEL_COIN        = 3'd7;

    localparam logic [4:0] IRQ_LINE_PHASE = 5'd16;
    localparam logic [7:0] TRIGGER_BASE   = 8'd72;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] address;
        logic [7:0]  write_data;
        logic [7:0]  paddle;
        logic [1:0]  coin_switches;
        logic [1:0]  start_switches;
        logic [1:0]  service_switches;
        logic        serve_button;
    } req_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       nmi_line;
        logic       tone_on;
        logic       lamp_zero;
        logic       lamp_one;
        logic       coin_counter;
        logic       watchdog_kick;
    } rsp_word_t;

endpackage
`default_nettype wire

[rtl/aio_core.sv]
`default_nettype none
module aio_core
    import aio_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic      accept,
    input  wire req_word_t word,
    output rsp_word_t      result
);

    logic [7:0] dip_reg;
    logic [1:0] gsel_reg;
    logic [8:0] hcount_reg, hcount_next;
    logic [8:0] vcount_reg, vcount_next;
    logic       irq_reg, irq_next;
    logic [1:0] pmask_reg, pmask_next;
    logic [1:0] ptrig_reg, ptrig_next;
    logic [7:0] tline_reg, tline_next;
    logic       thalf_reg, thalf_next;
    logic       tarmed_reg, tarmed_next;
    logic       sync_reg, sync_next;
    logic [7:0] tone_byte_reg, tone_byte_next;
    logic       tone_reg, tone_next;
    logic [2:0] lamp_reg, lamp_next;

    logic [8:0] h_inc, v_inc;
    logic [5:0] sw_off;
    logic [1:0] nmi_src;
    logic [7:0] sw_rd;
    logic [7:0] rd;
    logic       kick;
    logic       b0;

    assign nmi_src = ptrig_reg & ~pmask_reg;
    assign sw_off  = word.address[5:0];
    assign b0      = word.address[0];
    assign h_inc   = hcount_reg + 9'd1;
    assign v_inc   = vcount_reg + 9'd1;

    always_comb
    begin
        sw_rd = 8'hff;
        if ((sw_off & SW_DIP_MASK) == SW_DIP0)
            sw_rd = sw_rd & {dip_reg[1:0], 6'h3f};
        if ((sw_off & SW_DIP_MASK) == SW_DIP1)
            sw_rd = sw_rd & {dip_reg[3:2], 6'h3f};
        if ((sw_off & SW_DIP_MASK) == SW_DIP2)
            sw_rd = sw_rd & {dip_reg[7:6], 6'h3f};
        if ((sw_off & SW_DIP_MASK) == SW_DIP3)
            sw_rd = sw_rd & {dip_reg[5:4], 6'h3f};
        if ((sw_off & SW_BIT_MASK) == SW_GSEL_LO)
            sw_rd = sw_rd & {gsel_reg[0], 7'h7f};
        if ((sw_off & SW_BIT_MASK) == SW_TRIG0)
            sw_rd = sw_rd & {nmi_src[0], 7'h7f};
        if ((sw_off & SW_BIT_MASK) == SW_TRIG1)
            sw_rd = sw_rd & {nmi_src[1], 7'h7f};
        if ((sw_off & SW_BIT_MASK) == SW_SERVE)
            sw_rd = sw_rd & {word.serve_button, 7'h7f};
        if ((sw_off & SW_BIT_MASK) == SW_GSEL_HI)
            sw_rd = sw_rd & {gsel_reg[1], 7'h7f};
    end

    always_comb
    begin
        hcount_next    = hcount_reg;
        vcount_next    = vcount_reg;
        irq_next       = irq_reg;
        pmask_next     = pmask_reg;
        ptrig_next     = ptrig_reg;
        tline_next     = tline_reg;
        thalf_next     = thalf_reg;
        tarmed_next    = tarmed_reg;
        sync_next      = sync_reg;
        tone_byte_next = tone_byte_reg;
        tone_next      = tone_reg;
        lamp_next      = lamp_reg;
        rd             = 8'hff;
        kick           = 1'b0;
        unique case (word.mode)
            MODE_READ:
            begin
                priority if ((word.address & PAGE_MASK) == PAGE_SWITCH)
                    rd = sw_rd;
                else if ((word.address & PAGE_MASK) == PAGE_COIN)
                    rd = {word.coin_switches, 6'h3f};
                else if ((word.address & PAGE_MASK) == PAGE_START)
                    rd = {~word.start_switches, 6'h3f};
                else if ((word.address & PAGE_MASK) == PAGE_SERVICE)
                    rd = {~word.service_switches, 6'h3f};
                else if ((word.address & BLOCK_MASK) == BLOCK_LINE)
                begin
                    sync_next = ~hcount_reg[8] & hcount_reg[7];
                    rd        = vcount_reg[7:0];
                end
                else if ((word.address & BLOCK_MASK) == BLOCK_SYNC)
                    rd = {sync_reg, 7'h7f};
                else
                    rd = 8'hff;
            end
            MODE_WRITE:
            begin
                if (word.address == TONE_ADDR
                    || (word.address & TONE_MIR_MASK) == TONE_MIR_ADDR)
                    tone_byte_next = word.write_data;
                priority if ((word.address & WBLOCK_MASK) == WBLOCK_LATCH)
                begin
                    unique case (word.address[6:4])
                        WSEL_SERVE_LAMP:  lamp_next[0] = ~b0;
                        WSEL_START1_LAMP: lamp_next[0] = b0;
                        WSEL_START2_LAMP: lamp_next[1] = b0;
                        WSEL_MASK0:
                        begin
                            pmask_next[0] = ~b0;
                            ptrig_next[0] = 1'b0;
                        end
                        WSEL_MASK1:
                        begin
                            pmask_next[1] = ~b0;
                            ptrig_next[1] = 1'b0;
                        end
                        WSEL_COIN:        lamp_next[2] = b0;
                        default:          lamp_next = lamp_reg;
                    endcase
                end
                else if ((word.address & WBLOCK_MASK) == WBLOCK_WDOG)
                    kick = 1'b1;
                else if ((word.address & WBLOCK_MASK) == WBLOCK_IRQACK)
                    irq_next = 1'b0;
                else
                    kick = 1'b0;
            end
            MODE_TICK:
            begin
                hcount_next = h_inc;
                if ({1'b0, h_inc} >= LINE_PIXELS)
                begin
                    hcount_next = 9'd0;
                    vcount_next = v_inc;
                    if ({1'b0, v_inc} >= FRAME_LINES)
                        vcount_next = 9'd0;
                end
                if (hcount_next == 9'd0 && vcount_next[1:0] == 2'd0)
                begin
                    if (vcount_next[4:0] == IRQ_LINE_PHASE)
                        irq_next = 1'b1;
                    tone_next = |(tone_byte_reg & {1'b0, vcount_next[8:2]});
                    if (vcount_next == VISIBLE_LINES)
                    begin
                        tline_next  = TRIGGER_BASE + {1'b0, word.paddle[7:1]};
                        thalf_next  = word.paddle[0];
                        tarmed_next = 1'b1;
                    end
                end
                if (tarmed_next && vcount_next == {1'b0, tline_next}
                    && hcount_next == {1'b0, thalf_next, 7'd0})
                begin
                    ptrig_next[0] = 1'b1;
                    tarmed_next   = 1'b0;
                end
            end
            default:
            begin
                rd = 8'hff;
            end
        endcase
    end

    always_comb
    begin
        result.read_data     = rd;
        result.irq_line      = irq_next;
        result.nmi_line      = |(ptrig_next & ~pmask_next);
        result.tone_on       = tone_next;
        result.lamp_zero     = lamp_next[0];
        result.lamp_one      = lamp_next[1];
        result.coin_counter  = lamp_next[2];
        result.watchdog_kick = kick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_reg  <= DIP_RESET;
            gsel_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIP_SWITCHES: dip_reg  <= cfg_data;
                CFG_GAME_SELECT:  gsel_reg <= cfg_data[1:0];
                default:          dip_reg  <= dip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg    <= 9'd0;
            vcount_reg    <= 9'd0;
            irq_reg       <= 1'b0;
            pmask_reg     <= 2'd0;
            ptrig_reg     <= 2'd0;
            tline_reg     <= 8'd0;
            thalf_reg     <= 1'b0;
            tarmed_reg    <= 1'b0;
            sync_reg      <= 1'b0;
            tone_byte_reg <= 8'd0;
            tone_reg      <= 1'b0;
            lamp_reg      <= 3'd0;
        end
        else if (accept)
        begin
            hcount_reg    <= hcount_next;
            vcount_reg    <= vcount_next;
            irq_reg       <= irq_next;
            pmask_reg     <= pmask_next;
            ptrig_reg     <= ptrig_next;
            tline_reg     <= tline_next;
            thalf_reg     <= thalf_next;
            tarmed_reg    <= tarmed_next;
            sync_reg      <= sync_next;
            tone_byte_reg <= tone_byte_next;
            tone_reg      <= tone_next;
            lamp_reg      <= lamp_next;
        end
    end

endmodule
`default_nettype wire

[rtl/aio_out_buf.sv]
`default_nettype none
module aio_out_buf
    import aio_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rsp_word_t push_word,
    output logic           full,
    output logic           valid,
    input  wire logic      stall,
    output rsp_word_t      word
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    rsp_word_t out_word_reg;
    rsp_word_t skid_word_reg;
    logic      take;

    assign take  = out_valid_reg && !stall;
    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (take)
                    skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                if (!out_valid_reg || take)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_word_reg <= skid_word_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
                out_word_reg <= push_word;
            else
                skid_word_reg <= push_word;
        end
    end

endmodule
`default_nettype wire

[rtl/arcade_io_and_interrupt_unit.sv]
// I/O and interrupt unit for a small 6502 arcade board. Each word on req is a
// CPU read, a CPU write or one pixel tick of the beam, and gives exactly one
// word on rsp with the read byte (255 when nothing is read) and the levels of
// IRQ, NMI, tone, lamps and coin counter after that word, plus the watchdog
// pulse. Each word is decoded against the beam counters and latches and the
// response is registered in the same cycle, so req takes a word every cycle
// while req_stall is low. A two-deep output stage holds responses while rsp is
// stalled; req stalls only once both are full. The user, not the block, must
// write DIP switches and game select via cfg while no words are in flight.
`default_nettype none
module arcade_io_and_interrupt_unit
    import aio_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_word_t  req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_word_t       rsp
);

    logic      accept;
    logic      buf_full;
    rsp_word_t result;

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;

    aio_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (req),
        .result    (result)
    );

    aio_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result),
        .full      (buf_full),
        .valid     (rsp_valid),
        .stall     (rsp_stall),
        .word      (rsp)
    );

endmodule
`default_nettype wire
